FILE: design/lmfb_pkg.sv
// ----------------------------------------------------------------------------
// lmfb_pkg: shared types, constants and helpers for the led matrix frame buffer
// Holds the command and result beat types, the opcodes and the column word
// transforms used by the sequencer and the datapath.
// ----------------------------------------------------------------------------
package lmfb_pkg;

  // sign geometry
  localparam int unsigned COLUMNS = 90;
  localparam int unsigned ROWS    = 7;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 3;
  localparam int unsigned ADDR_W  = $clog2(COLUMNS);

  localparam logic [ROWS-1:0]   ROW_MASK  = {ROWS{1'b1}};
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(COLUMNS - 1);

  // command codes
  typedef enum logic [3:0] {
    OP_FILL_LIT    = 4'd0,
    OP_FILL_DARK   = 4'd1,
    OP_WRITE_COL   = 4'd2,
    OP_READ_COL    = 4'd3,
    OP_INVERT      = 4'd4,
    OP_PIXEL_ON    = 4'd5,
    OP_PIXEL_OFF   = 4'd6,
    OP_ROLL_DOWN   = 4'd7,
    OP_ROLL_UP     = 4'd8,
    OP_SHIFT_RIGHT = 4'd9
  } op_e;

  // command beat
  typedef struct packed {
    op_e              op;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic [ROWS-1:0]  column_bits;
  } in_t;

  // result beat
  typedef struct packed {
    logic [ROWS-1:0] read_bits;
    logic            column_valid;
  } out_t;

  // sequencer to datapath control
  typedef struct packed {
    logic              idle;
    logic              col_stage;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              sw_wr;
    logic [ADDR_W-1:0] sw_addr;
    in_t               cmd;
  } seq_ctrl_t;

  // column number lies on the sign
  function automatic logic in_range(logic [COL_W-1:0] column);
    return {1'b0, column} < (COL_W + 1)'(COLUMNS);
  endfunction

  // row n takes row n-1, row 0 takes the top row
  function automatic logic [ROWS-1:0] rot_down(logic [ROWS-1:0] w);
    return {w[ROWS-2:0], w[ROWS-1]};
  endfunction

  // row n takes row n+1, the top row takes row 0
  function automatic logic [ROWS-1:0] rot_up(logic [ROWS-1:0] w);
    return {w[0], w[ROWS-1:1]};
  endfunction

endpackage

FILE: design/lmfb_ram.sv
// ----------------------------------------------------------------------------
// lmfb_ram: generic simple dual port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lmfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/lmfb_seq.sv
// ----------------------------------------------------------------------------
// lmfb_seq: command sequencer
// Issues the column read of a single column command and walks the whole
// buffer for fill lit, invert, roll and shift, one column write and at most
// one column read per cycle.
// ----------------------------------------------------------------------------
module lmfb_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  lmfb_pkg::in_t       cmd_i,
  output lmfb_pkg::seq_ctrl_t ctrl_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_COL   = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DRAIN = 4'b1000
  } state_e;

  state_e                      state_q, state_d;
  lmfb_pkg::in_t               cmd_q, cmd_d;
  logic [lmfb_pkg::ADDR_W-1:0] cnt_q, cnt_d;
  logic                        sw_wr_q, sw_wr_d;
  logic [lmfb_pkg::ADDR_W-1:0] sw_addr_q, sw_addr_d;
  logic                        rd_en;
  logic [lmfb_pkg::ADDR_W-1:0] rd_addr;
  logic                        shift;

  assign shift = (cmd_q.op == lmfb_pkg::OP_SHIFT_RIGHT);

  // next state and read issue
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    cnt_d     = cnt_q;
    sw_wr_d   = 1'b0;
    sw_addr_d = sw_addr_q;
    rd_en     = 1'b0;
    rd_addr   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d = cmd_i;
          cnt_d = '0;
          unique case (cmd_i.op) inside
            lmfb_pkg::OP_WRITE_COL, lmfb_pkg::OP_READ_COL,
            lmfb_pkg::OP_PIXEL_ON, lmfb_pkg::OP_PIXEL_OFF: begin
              state_d = S_COL;
              rd_en   = lmfb_pkg::in_range(cmd_i.column);
              rd_addr = cmd_i.column[lmfb_pkg::ADDR_W-1:0];
            end
            lmfb_pkg::OP_FILL_LIT, lmfb_pkg::OP_INVERT, lmfb_pkg::OP_ROLL_DOWN,
            lmfb_pkg::OP_ROLL_UP, lmfb_pkg::OP_SHIFT_RIGHT: begin
              state_d = S_SWEEP;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_COL: begin
        state_d = S_IDLE;
      end
      S_SWEEP: begin
        // shift walks downward so every source is read before it is overwritten
        sw_addr_d = shift ? (lmfb_pkg::LAST_ADDR - cnt_q) : cnt_q;
        sw_wr_d   = 1'b1;
        rd_en     = (cmd_q.op != lmfb_pkg::OP_FILL_LIT) && !(shift && sw_addr_d == '0);
        rd_addr   = shift ? (sw_addr_d - lmfb_pkg::ADDR_W'(1)) : cnt_q;
        cnt_d     = cnt_q + lmfb_pkg::ADDR_W'(1);
        if (cnt_q == lmfb_pkg::LAST_ADDR) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      sw_wr_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sw_wr_q <= sw_wr_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    sw_addr_q <= sw_addr_d;
  end

  assign ctrl_o.idle      = (state_q == S_IDLE);
  assign ctrl_o.col_stage = (state_q == S_COL);
  assign ctrl_o.rd_en     = rd_en;
  assign ctrl_o.rd_addr   = rd_addr;
  assign ctrl_o.sw_wr     = sw_wr_q;
  assign ctrl_o.sw_addr   = sw_addr_q;
  assign ctrl_o.cmd       = cmd_q;

endmodule

FILE: design/led_matrix_frame_buffer.sv
// ----------------------------------------------------------------------------
// led_matrix_frame_buffer: frame buffer of a seven-row led sign
// Column store in one ram with read-modify-write per command.
// ----------------------------------------------------------------------------
// Each command beat gives exactly one result beat. Column write, column read
// and pixel commands issue the registered ram read on acceptance, and all but
// column read modify and write back in the column stage. Fill lit, invert,
// both rolls and shift right walk the whole column ram, one column per cycle
// through the single read and single write port, followed by a drain state;
// their result beat is posted right at acceptance. Fill dark and unused codes
// keep the sequencer idle, since fill dark only clears the per-column valid
// flags; an unwritten column reads as dark, so no clearing pass follows reset.
// A new command is taken once the sequencer is idle and the result register
// is empty or being drained in the same cycle.
module led_matrix_frame_buffer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lmfb_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lmfb_pkg::out_t out_data_o
);

  lmfb_pkg::seq_ctrl_t         ctrl;
  logic                        in_fire;
  logic [lmfb_pkg::COLUMNS-1:0] vld_q, vld_d;
  logic                        rvalid_q;
  logic [lmfb_pkg::ROWS-1:0]   rdata;
  logic [lmfb_pkg::ROWS-1:0]   rword;
  logic                        col_ok;
  logic                        row_ok;
  logic                        col_wr;
  logic [lmfb_pkg::ROWS-1:0]   col_word;
  logic [lmfb_pkg::ROWS-1:0]   sw_word;
  logic                        mem_we;
  logic [lmfb_pkg::ADDR_W-1:0] mem_waddr;
  logic [lmfb_pkg::ROWS-1:0]   mem_wdata;
  logic                        out_valid_q, out_valid_d;
  lmfb_pkg::out_t              out_q, out_d;
  logic                        load_now;
  logic                        col_op;

  // command acceptance
  assign in_ready_o = ctrl.idle && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  lmfb_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .cmd_i   (in_data_i),
    .ctrl_o  (ctrl)
  );

  lmfb_ram #(
    .WIDTH (lmfb_pkg::ROWS),
    .DEPTH (lmfb_pkg::COLUMNS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (ctrl.rd_en),
    .raddr_i (ctrl.rd_addr),
    .rdata_o (rdata)
  );

  // valid flag of the column being read, follows the ram latency
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else if (ctrl.rd_en) begin
      rvalid_q <= vld_q[ctrl.rd_addr];
    end
  end

  // column never written since reset or fill dark reads dark
  assign rword = rvalid_q ? rdata : '0;

  // single column modify
  assign col_ok = lmfb_pkg::in_range(ctrl.cmd.column);
  assign row_ok = ctrl.cmd.row < lmfb_pkg::ROW_W'(lmfb_pkg::ROWS);

  always_comb begin
    col_wr   = 1'b0;
    col_word = rword;
    case (ctrl.cmd.op)
      lmfb_pkg::OP_WRITE_COL: begin
        col_wr   = col_ok;
        col_word = ctrl.cmd.column_bits;
      end
      lmfb_pkg::OP_PIXEL_ON: begin
        col_wr   = col_ok && row_ok;
        col_word = rword | (lmfb_pkg::ROWS'(1) << ctrl.cmd.row);
      end
      lmfb_pkg::OP_PIXEL_OFF: begin
        col_wr   = col_ok && row_ok;
        col_word = rword & ~(lmfb_pkg::ROWS'(1) << ctrl.cmd.row);
      end
      default: begin
        col_wr   = 1'b0;
      end
    endcase
    col_wr = col_wr && ctrl.col_stage;
  end

  // whole buffer transform of one column
  always_comb begin
    case (ctrl.cmd.op)
      lmfb_pkg::OP_FILL_LIT:    sw_word = lmfb_pkg::ROW_MASK;
      lmfb_pkg::OP_INVERT:      sw_word = rword ^ lmfb_pkg::ROW_MASK;
      lmfb_pkg::OP_ROLL_DOWN:   sw_word = lmfb_pkg::rot_down(rword);
      lmfb_pkg::OP_ROLL_UP:     sw_word = lmfb_pkg::rot_up(rword);
      lmfb_pkg::OP_SHIFT_RIGHT: sw_word = (ctrl.sw_addr == '0) ? '0 : rword;
      default:                  sw_word = rword;
    endcase
  end

  // ram write port
  assign mem_we    = col_wr || ctrl.sw_wr;
  assign mem_waddr = ctrl.col_stage ? ctrl.cmd.column[lmfb_pkg::ADDR_W-1:0] : ctrl.sw_addr;
  assign mem_wdata = ctrl.col_stage ? col_word : sw_word;

  // per column valid flags
  always_comb begin
    vld_d = vld_q;
    if (in_fire && in_data_i.op == lmfb_pkg::OP_FILL_DARK) begin
      vld_d = '0;
    end
    if (mem_we) begin
      vld_d[mem_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // result register
  always_comb begin
    col_op = 1'b0;
    case (in_data_i.op) inside
      lmfb_pkg::OP_WRITE_COL, lmfb_pkg::OP_READ_COL,
      lmfb_pkg::OP_PIXEL_ON, lmfb_pkg::OP_PIXEL_OFF: col_op = 1'b1;
      default:                                       col_op = 1'b0;
    endcase
  end

  assign load_now = in_fire && !col_op;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_now) begin
      out_valid_d        = 1'b1;
      out_d.read_bits    = '0;
      out_d.column_valid = 1'b0;
    end else if (ctrl.col_stage) begin
      out_valid_d        = 1'b1;
      out_d.read_bits    = (ctrl.cmd.op == lmfb_pkg::OP_READ_COL && col_ok) ? rword : '0;
      out_d.column_valid = col_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // no command taken while a sweep write is still in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> !ctrl.sw_wr)
    else $error("command accepted during sweep write");

  // a pending result beat is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_now || ctrl.col_stage) |-> !(out_valid_q && !out_ready_i))
    else $error("result register overwritten");

  // ram writes stay on the sign
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ({1'b0, mem_waddr} < (lmfb_pkg::ADDR_W + 1)'(lmfb_pkg::COLUMNS)))
    else $error("ram write beyond last column");

  // the column modify stage always follows an accepted command
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctrl.col_stage |-> $past(in_fire))
    else $error("column stage without accepted command");

endmodule
